/* rtl/core/mbps_pkg.sv */
package mbps_pkg;

  // fixed register file layout: four 64-bit pattern words, 32 care bits
  localparam int PAT_BYTES = 32;
  localparam int PAT_IDX_W = 5;
  localparam int PAT_BITS = PAT_BYTES * 8;
  localparam int LEN_W = 6;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DATA_W = 64;
  localparam int ADDR_W = 32;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_PAT_0_7   = 3'd0,
    REG_PAT_8_15  = 3'd1,
    REG_PAT_16_23 = 3'd2,
    REG_PAT_24_31 = 3'd3,
    REG_CARE_MASK = 3'd4,
    REG_PAT_LEN   = 3'd5
  } mbps_reg_t;

  // settings seen by every cell
  typedef struct packed {
    logic [PAT_BITS-1:0]  pattern;
    logic [PAT_BYTES-1:0] care;
    logic [PAT_IDX_W-1:0] len_m1;
  } mbps_match_cfg_t;

  // per-word chain control
  typedef struct packed {
    logic shift;
    logic flush;
  } mbps_ctl_t;

endpackage

/* rtl/core/masked_byte_pattern_scanner_core.sv */
// Masked byte pattern scanner.
// Input words carry one memory byte with its address; in_tuser marks the
// first byte of a region and in_tlast the final byte of the whole scan.
// A match is a window of pattern_length bytes inside one region where every
// position with its care bit set equals the pattern byte. The first match
// of a scan gives one output word: out_tuser = 1 and out_tdata = start
// address. A scan that ends with no match gives out_tuser = 0, out_tdata = 0.
// Throughput is one byte per cycle while in_tready is high: the window is a
// row of byte cells that shift once per accepted word and compare in parallel.
// The result is in the output register on the cycle after the completing
// byte is accepted.
// The configuration port is always ready; writes apply from the next byte.
// Reset clears settings to defaults (length 1), the window and the output.
// When the receiver stalls, the output word holds and in_tready drops only
// while that word is still waiting and out_tready is low.
module masked_byte_pattern_scanner_core
  import mbps_pkg::*;
#(
  parameter int PATTERN_MAX = 32
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [39:0]           in_tdata,   // data_byte[7:0], byte_address[39:8]
  input  logic                  in_tuser,   // region_first
  input  logic                  in_tlast,   // scan_last
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [ADDR_W-1:0]     out_tdata,  // match_address[31:0]
  output logic                  out_tuser,  // found
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  mbps_match_cfg_t  match_cfg;
  mbps_ctl_t        ctl;

  logic [PATTERN_MAX-1:0] valid_w;
  logic [PATTERN_MAX-1:0] ok_w;
  logic [7:0]             byte_w [PATTERN_MAX];

  logic              acc;
  logic              hit;
  logic              hit_new;
  logic              emit;
  logic [7:0]        in_byte;
  logic [ADDR_W-1:0] in_addr;

  logic              reported_r;
  logic              reported_nxt;
  logic              out_valid_r;
  logic              out_valid_nxt;
  logic              out_found_r;
  logic              out_found_nxt;
  logic [ADDR_W-1:0] out_addr_r;
  logic [ADDR_W-1:0] out_addr_nxt;

  mbps_cfg_regs #(
    .PATTERN_MAX(PATTERN_MAX)
  ) u_cfg (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data),
    .match_cfg(match_cfg)
  );

  assign in_byte   = in_tdata[7:0];
  assign in_addr   = in_tdata[39:8];
  assign in_tready = !out_valid_r || out_tready;
  assign acc       = in_tvalid && in_tready;

  assign ctl.shift = acc;
  assign ctl.flush = in_tlast;

  genvar gi;
  generate
    for (gi = 0; gi < PATTERN_MAX; gi++) begin : g_cell
      logic [7:0] b_in;
      logic       v_in;
      if (gi == 0) begin : g_head
        assign b_in = in_byte;
        assign v_in = 1'b1;
      end else begin : g_link
        // a region start drops everything behind the newest byte
        assign b_in = byte_w[gi-1];
        assign v_in = valid_w[gi-1] & ~in_tuser;
      end
      mbps_cell #(
        .IDX(gi)
      ) u_cell (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctl      (ctl),
        .match_cfg(match_cfg),
        .byte_in  (b_in),
        .valid_in (v_in),
        .byte_q   (byte_w[gi]),
        .valid_q  (valid_w[gi]),
        .ok       (ok_w[gi])
      );
    end
  endgenerate

  assign hit     = &ok_w;
  assign hit_new = acc && hit && !reported_r;
  assign emit    = hit_new || (acc && in_tlast && !reported_r);

  always_comb begin
    reported_nxt  = reported_r;
    out_valid_nxt = out_valid_r;
    out_found_nxt = out_found_r;
    out_addr_nxt  = out_addr_r;
    if (acc) begin
      reported_nxt = in_tlast ? 1'b0 : (reported_r | hit);
    end
    if (emit) begin
      out_valid_nxt = 1'b1;
      out_found_nxt = hit_new;
      out_addr_nxt  = hit_new ? (in_addr - ADDR_W'(match_cfg.len_m1)) : '0;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      reported_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      reported_r  <= reported_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_found_r <= out_found_nxt;
    out_addr_r  <= out_addr_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_found_r;
  assign out_tdata  = out_addr_r;

  // a new output word only follows an accepted input word
  assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_tvalid) |-> $past(in_tvalid && in_tready))
    else $error("output word without accepted input");

  // not-found words carry a zero address
  assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tuser) |-> (out_tdata == '0))
    else $error("not-found word with nonzero address");

  // end of scan empties the window and rearms reporting
  assert property (@(posedge clk) disable iff (!rst_n)
    (acc && in_tlast) |=> (!reported_r && (valid_w == '0)))
    else $error("scan end did not clear state");

  // window fill stays contiguous from the newest byte
  assert property (@(posedge clk) disable iff (!rst_n)
    ((valid_w & (valid_w + PATTERN_MAX'(1))) == '0))
    else $error("window valid bits not contiguous");

  // a reported match blocks further results until scan end
  assert property (@(posedge clk) disable iff (!rst_n)
    (hit_new && !in_tlast) |=> reported_r)
    else $error("match not recorded");

endmodule

/* rtl/core/mbps_cfg_regs.sv */
module mbps_cfg_regs
  import mbps_pkg::*;
#(
  parameter int PATTERN_MAX = 32
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  output mbps_match_cfg_t       match_cfg
);

  localparam logic [LEN_W-1:0] LEN_MAX = LEN_W'(PATTERN_MAX);

  logic [3:0][CFG_DATA_W-1:0] pat_r;
  logic [PAT_BYTES-1:0]       care_r;
  logic [LEN_W-1:0]           len_r;
  logic [LEN_W-1:0]           len_use;
  logic                       wr_en;

  assign cfg_ready = 1'b1;
  assign wr_en = cfg_valid & cfg_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pat_r  <= '0;
      care_r <= '0;
      len_r  <= LEN_W'(1);
    end else if (wr_en) begin
      case (mbps_reg_t'(cfg_index))
        REG_PAT_0_7:   pat_r[0] <= cfg_data;
        REG_PAT_8_15:  pat_r[1] <= cfg_data;
        REG_PAT_16_23: pat_r[2] <= cfg_data;
        REG_PAT_24_31: pat_r[3] <= cfg_data;
        REG_CARE_MASK: care_r <= cfg_data[PAT_BYTES-1:0];
        REG_PAT_LEN:   len_r <= cfg_data[LEN_W-1:0];
        default: ;
      endcase
    end
  end

  // zero acts as one, oversize clamps to the cell count
  always_comb begin
    len_use = len_r;
    if (len_r == '0) begin
      len_use = LEN_W'(1);
    end else if (len_r > LEN_MAX) begin
      len_use = LEN_MAX;
    end
    match_cfg.pattern = pat_r;
    match_cfg.care    = care_r;
    match_cfg.len_m1  = PAT_IDX_W'(len_use - LEN_W'(1));
  end

endmodule

/* rtl/core/mbps_cell.sv */
module mbps_cell
  import mbps_pkg::*;
#(
  parameter int IDX = 0
) (
  input  logic            clk,
  input  logic            rst_n,
  input  mbps_ctl_t       ctl,
  input  mbps_match_cfg_t match_cfg,
  input  logic [7:0]      byte_in,
  input  logic            valid_in,
  output logic [7:0]      byte_q,
  output logic            valid_q,
  output logic            ok
);

  localparam logic [PAT_IDX_W-1:0] IDX_C = PAT_IDX_W'(IDX);

  logic [7:0]           byte_r;
  logic [7:0]           byte_nxt;
  logic                 valid_r;
  logic                 valid_nxt;
  logic [PAT_IDX_W-1:0] sel;
  logic                 in_use;
  logic                 is_oldest;
  logic [7:0]           pat_byte;
  logic                 care_bit;

  // this cell holds the byte IDX back from the newest; it faces
  // pattern position len-1-IDX
  always_comb begin
    in_use    = IDX_C <= match_cfg.len_m1;
    is_oldest = IDX_C == match_cfg.len_m1;
    sel       = match_cfg.len_m1 - IDX_C;
    pat_byte  = match_cfg.pattern[{sel, 3'b000} +: 8];
    care_bit  = match_cfg.care[sel];
    ok = !in_use || ((!care_bit || (byte_in == pat_byte)) && (!is_oldest || valid_in));
  end

  always_comb begin
    byte_nxt  = byte_r;
    valid_nxt = valid_r;
    if (ctl.shift) begin
      byte_nxt  = byte_in;
      valid_nxt = valid_in & ~ctl.flush;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    byte_r <= byte_nxt;
  end

  assign byte_q  = byte_r;
  assign valid_q = valid_r;

endmodule
